@@ design/banked_memory_map_decoder_defines.svh @@
// Assertion helpers shared by the decoder modules.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef BANKED_MEMORY_MAP_DECODER_DEFINES_SVH
`define BANKED_MEMORY_MAP_DECODER_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent
`define BMMD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent
`define BMMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/bmmd_pkg.sv @@
`default_nettype none
package bmmd_pkg;

  // Storage geometry
  localparam int unsigned RAM_BYTES   = 65536;
  localparam int unsigned RAM_AW      = 16;
  localparam int unsigned COLOR_CELLS = 1024;
  localparam int unsigned COLOR_AW    = 10;
  localparam int unsigned BASIC_BYTES = 8192;
  localparam int unsigned BASIC_AW    = 13;
  localparam int unsigned KERNEL_BYTES = 8192;
  localparam int unsigned KERNEL_AW   = 13;
  localparam int unsigned GLYPH_BYTES = 4096;
  localparam int unsigned GLYPH_AW    = 12;

  // I/O register addresses
  localparam logic [15:0] ADDR_VIDEO_MODE = 16'hD018;
  localparam logic [15:0] ADDR_BORDER     = 16'hD020;
  localparam logic [15:0] ADDR_BACKGROUND = 16'hD021;
  localparam logic [15:0] ADDR_KEY_COLUMN = 16'hDC00;
  localparam logic [15:0] ADDR_KEY_SCAN   = 16'hDC01;

  // Reset values of the first two RAM bytes
  localparam logic [7:0] RAM0_RESET = 8'hEF;
  localparam logic [7:0] RAM1_RESET = 8'h07;

  // Color read pads the upper nibble
  localparam logic [7:0] COLOR_PAD = 8'hF0;
  localparam logic [3:0] NIBBLE_MASK = 4'hF;

  // Screen codes that hide color changes
  localparam logic [7:0] CHAR_SPACE  = 8'd32;
  localparam logic [7:0] CHAR_SHIFTED_SPACE = 8'd96;

  // Screen cell window: RAM 1024 .. 2023
  localparam logic [5:0] SCREEN_PAGE = 6'd1;
  localparam logic [9:0] SCREEN_CELLS = 10'd1000;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_LOAD  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    RD_NONE   = 2'd0,
    RD_CELL   = 2'd1,
    RD_SCREEN = 2'd2,
    RD_BORDER = 2'd3
  } redraw_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL
  } state_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [63:0] key_matrix;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    redraw_e    redraw_kind;
    logic [9:0] cell_index;
    logic [7:0] border_value;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic clear;
    logic capture;
    logic commit;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
    logic slot_free;
  } ctrl_status_t;

endpackage
`default_nettype wire

@@ design/banked_memory_map_decoder.sv @@
// Bus-access decoder for a banked 64K memory map. After reset the block sweeps main RAM
// and color RAM to zero, one address per cycle, through all 65536 RAM addresses; in_ready_o
// stays low until the sweep ends. Each access is then handled first by a capture that
// reads all memories through their registered read ports, then by a step that decodes, commits
// stores and loads the output register once it is free. A finished result waits there while
// the next access is taken. The ROM images hold no defined content until they are loaded with
// load accesses.
`default_nettype none
module banked_memory_map_decoder (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire bmmd_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output bmmd_pkg::out_item_t      out_data_o
);
  import bmmd_pkg::*;

  ctrl_cmd_t    ctrl_cmd;
  ctrl_status_t ctrl_status;

  // Sequence the accesses
  bmmd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (ctrl_status),
    .cmd_o      (ctrl_cmd)
  );

  // Memories, registers and decode
  bmmd_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (ctrl_cmd),
    .status_o    (ctrl_status),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

@@ design/bmmd_ctrl.sv @@
`default_nettype none
module bmmd_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire bmmd_pkg::ctrl_status_t status_i,
  output bmmd_pkg::ctrl_cmd_t        cmd_o
);
  import bmmd_pkg::*;

  `include "banked_memory_map_decoder_defines.svh"

  state_e state_q, state_d;

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Advance: sweep, wait for a transfer, evaluate and commit
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (status_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (status_i.slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // Drive commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: cmd_o.clear = 1'b1;
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_EVAL: cmd_o.commit = status_i.slot_free;
      default: cmd_o = '0;
    endcase
  end

  `BMMD_ASSERT_SAME(a_commit_needs_slot, cmd_o.commit, status_i.slot_free,
                    "commit without a free output slot")
  `BMMD_ASSERT_NEXT(a_capture_then_eval, cmd_o.capture, state_q == ST_EVAL,
                    "capture not followed by evaluation")
  `BMMD_ASSERT_SAME(a_no_accept_in_clear, cmd_o.clear, !in_ready_o && !cmd_o.capture,
                    "transfer taken during clearing sweep")

endmodule
`default_nettype wire

@@ design/bmmd_datapath.sv @@
`default_nettype none
module bmmd_datapath (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire bmmd_pkg::ctrl_cmd_t cmd_i,
  output bmmd_pkg::ctrl_status_t   status_o,
  input  wire bmmd_pkg::in_item_t  in_data_i,
  input  wire logic                out_ready_i,
  output logic                     out_valid_o,
  output bmmd_pkg::out_item_t      out_data_o
);
  import bmmd_pkg::*;

  `include "banked_memory_map_decoder_defines.svh"

  // Memories
  logic [7:0] main_ram_mem  [RAM_BYTES];
  logic [7:0] color_ram_mem [COLOR_CELLS];
  logic [7:0] basic_mem     [BASIC_BYTES];
  logic [7:0] kernel_mem    [KERNEL_BYTES];
  logic [7:0] glyph_mem     [GLYPH_BYTES];

  in_item_t        item_q;
  logic [7:0]      ram_rd_q, color_rd_q, basic_rd_q, kernel_rd_q, glyph_rd_q, scan_q;
  logic [RAM_AW-1:0] clr_cnt_q;
  logic [7:0]      ram0_q, ram1_q, video_q, keycol_q;
  logic [3:0]      border_q, background_q;
  logic            out_valid_q;
  out_item_t       out_data_q;

  // Read address: a color write looks up the screen byte behind its cell
  logic [RAM_AW-1:0] ram_raddr;
  logic              cap_color_wr;
  logic [7:0]        scan_rows;

  always_comb begin
    cap_color_wr = (in_data_i.cmd == CMD_WRITE) && (in_data_i.address[15:10] == 6'b110110)
                   && (ram1_q[2:0] != 3'd0);
    ram_raddr = cap_color_wr ? {SCREEN_PAGE, in_data_i.address[COLOR_AW-1:0]}
                             : in_data_i.address;
  end

  // Scan the key matrix against the current column byte
  always_comb begin
    scan_rows = '0;
    for (int c = 0; c < 8; c++) begin
      for (int r = 0; r < 8; r++) begin
        scan_rows[r] = scan_rows[r] | (in_data_i.key_matrix[c*8+r] & ~keycol_q[c]);
      end
    end
  end

  // Decode of the captured access
  logic [15:0] a;
  logic [7:0]  d;
  logic [7:0]  bank;
  logic        in_basic, in_io, in_kernel, in_color, to_ram;
  logic        is_write, is_load;
  logic        ram_we, color_we, basic_we, kernel_we, glyph_we;
  logic [7:0]  ram_byte, io_byte, rd_byte;
  out_item_t   res;

  always_comb begin
    a         = item_q.address;
    d         = item_q.write_data;
    bank      = ram1_q;
    in_basic  = (a[15:13] == 3'b101);
    in_io     = (a[15:12] == 4'hD);
    in_kernel = (a[15:13] == 3'b111);
    in_color  = (a[15:10] == 6'b110110);
    to_ram    = !in_io || (bank[2:0] == 3'd0);
    is_write  = (item_q.cmd == CMD_WRITE);
    is_load   = (item_q.cmd == CMD_LOAD);
    ram_we    = cmd_i.commit && is_write && to_ram;
    color_we  = cmd_i.commit && is_write && !to_ram && in_color;
    basic_we  = cmd_i.commit && is_load && in_basic;
    kernel_we = cmd_i.commit && is_load && in_kernel;
    glyph_we  = cmd_i.commit && is_load && in_io;
  end

  // Select the byte a read sees
  always_comb begin
    if (a == 16'd0) begin
      ram_byte = ram0_q;
    end else if (a == 16'd1) begin
      ram_byte = ram1_q;
    end else begin
      ram_byte = ram_rd_q;
    end

    if (in_color) begin
      io_byte = color_rd_q | COLOR_PAD;
    end else if (a == ADDR_KEY_SCAN) begin
      io_byte = scan_q;
    end else if (a == ADDR_VIDEO_MODE) begin
      io_byte = video_q;
    end else if (a == ADDR_BORDER) begin
      io_byte = {4'd0, border_q};
    end else if (a == ADDR_BACKGROUND) begin
      io_byte = {4'd0, background_q};
    end else if (a == ADDR_KEY_COLUMN) begin
      io_byte = keycol_q;
    end else begin
      io_byte = 8'd0;
    end

    if (in_basic) begin
      rd_byte = (bank[1:0] != 2'b11) ? ram_byte : basic_rd_q;
    end else if (in_kernel) begin
      rd_byte = !bank[1] ? ram_byte : kernel_rd_q;
    end else if (in_io) begin
      if (bank[1:0] == 2'b00) begin
        rd_byte = ram_byte;
      end else if (!bank[2]) begin
        rd_byte = glyph_rd_q;
      end else begin
        rd_byte = io_byte;
      end
    end else begin
      rd_byte = ram_byte;
    end
  end

  // Build the result item
  always_comb begin
    res = '0;
    case (item_q.cmd)
      CMD_READ: res.read_data = rd_byte;
      CMD_WRITE: begin
        if (to_ram) begin
          if ((ram_byte != d) && (a[15:10] == SCREEN_PAGE)
              && (a[COLOR_AW-1:0] < SCREEN_CELLS)) begin
            res.redraw_kind = RD_CELL;
            res.cell_index  = a[COLOR_AW-1:0];
          end
        end else if (a == ADDR_VIDEO_MODE) begin
          res.redraw_kind = RD_SCREEN;
        end else if (a == ADDR_BORDER) begin
          res.redraw_kind  = RD_BORDER;
          res.border_value = d;
        end else if (a == ADDR_BACKGROUND) begin
          res.redraw_kind = RD_SCREEN;
        end else if (in_color) begin
          if ((color_rd_q != d) && (ram_rd_q != CHAR_SPACE)
              && (ram_rd_q != CHAR_SHIFTED_SPACE)) begin
            res.redraw_kind = RD_CELL;
            res.cell_index  = a[COLOR_AW-1:0];
          end
        end
      end
      default: res = '0;
    endcase
  end

  // Capture the access and its memory reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q      <= in_data_i;
      ram_rd_q    <= main_ram_mem[ram_raddr];
      color_rd_q  <= color_ram_mem[in_data_i.address[COLOR_AW-1:0]];
      basic_rd_q  <= basic_mem[in_data_i.address[BASIC_AW-1:0]];
      kernel_rd_q <= kernel_mem[in_data_i.address[KERNEL_AW-1:0]];
      glyph_rd_q  <= glyph_mem[in_data_i.address[GLYPH_AW-1:0]];
      scan_q      <= ~scan_rows;
    end
  end

  // Write main and color RAM; sweep them to zero after reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      main_ram_mem[clr_cnt_q]                 <= 8'd0;
      color_ram_mem[clr_cnt_q[COLOR_AW-1:0]] <= 8'd0;
    end else begin
      if (ram_we) main_ram_mem[a] <= d;
      if (color_we) color_ram_mem[a[COLOR_AW-1:0]] <= d;
    end
  end

  // Load ROM images
  always_ff @(posedge clk_i) begin
    if (basic_we) basic_mem[a[BASIC_AW-1:0]] <= d;
    if (kernel_we) kernel_mem[a[KERNEL_AW-1:0]] <= d;
    if (glyph_we) glyph_mem[a[GLYPH_AW-1:0]] <= d;
  end

  // Advance the sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // Bank bytes and I/O registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram0_q       <= RAM0_RESET;
      ram1_q       <= RAM1_RESET;
      video_q      <= '0;
      border_q     <= '0;
      background_q <= '0;
      keycol_q     <= '0;
    end else if (cmd_i.commit && is_write) begin
      if (to_ram) begin
        if (a == 16'd0) ram0_q <= d;
        if (a == 16'd1) ram1_q <= d;
      end else begin
        if (a == ADDR_VIDEO_MODE) video_q <= d;
        if (a == ADDR_BORDER) border_q <= d[3:0] & NIBBLE_MASK;
        if (a == ADDR_BACKGROUND) background_q <= d[3:0] & NIBBLE_MASK;
        if (a == ADDR_KEY_COLUMN) keycol_q <= d;
      end
    end
  end

  // Output register: fill on commit, drop on transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) out_data_q <= res;
  end

  assign out_valid_o         = out_valid_q;
  assign out_data_o          = out_data_q;
  assign status_o.clear_last = &clr_cnt_q;
  assign status_o.slot_free  = !out_valid_q || out_ready_i;

  `BMMD_ASSERT_NEXT(a_commit_fills_slot, cmd_i.commit, out_valid_q,
                    "committed result not presented")
  `BMMD_ASSERT_NEXT(a_bank_only_on_commit, !cmd_i.commit, $stable(ram1_q),
                    "bank byte changed without a commit")
  `BMMD_ASSERT_SAME(a_no_commit_in_sweep, cmd_i.clear, !cmd_i.commit && !cmd_i.capture,
                    "access handled during clearing sweep")

endmodule
`default_nettype wire

@@ bench/bmmd_bus_checker.sv @@
`default_nettype none
module bmmd_bus_checker (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                in_ready_i,
  input  wire bmmd_pkg::in_item_t  in_data_i,
  input  wire logic                out_valid_i,
  input  wire logic                out_ready_i,
  input  wire bmmd_pkg::out_item_t out_data_i,
  output int                       fail_count_o,
  output int                       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import bmmd_pkg::*;

  // Shadow copy of every store in the decoder
  logic [7:0] ram_copy    [RAM_BYTES];
  logic [7:0] color_copy  [COLOR_CELLS];
  logic [7:0] basic_copy  [BASIC_BYTES];
  logic [7:0] kernel_copy [KERNEL_BYTES];
  logic [7:0] glyph_copy  [GLYPH_BYTES];
  logic [7:0] video_mode;
  logic [7:0] key_column;
  logic [3:0] border_nib;
  logic [3:0] background_nib;

  out_item_t expected_results [$];
  int        mismatches;
  int        results_seen;

  // Print one line per mismatch and count it
  task automatic report_mismatch(string msg);
    mismatches++;
    $display("MISMATCH at %0t ns, result %0d: %s", $realtime, results_seen, msg);
  endtask

  // Row bits read low when a pressed key sits in a selected (low) column
  function automatic logic [7:0] scan_rows(logic [63:0] keys);
    logic [7:0] rows;
    rows = 8'h00;
    for (int c = 0; c < 8; c++) begin
      if (!key_column[c]) rows = rows | keys[c*8 +: 8];
    end
    return ~rows;
  endfunction

  // Resolve a read through the bank bits in RAM byte 1
  function automatic logic [7:0] read_byte(logic [15:0] a, logic [63:0] keys);
    logic [7:0] bank;
    bank = ram_copy[1];
    if (a < 16'hA000 || (a >= 16'hC000 && a < 16'hD000)) return ram_copy[a];
    if (a < 16'hC000) return (bank[1:0] != 2'b11) ? ram_copy[a] : basic_copy[a[12:0]];
    if (a >= 16'hE000) return !bank[1] ? ram_copy[a] : kernel_copy[a[12:0]];
    if (bank[1:0] == 2'b00) return ram_copy[a];
    if (!bank[2]) return glyph_copy[a[11:0]];
    if (a >= 16'hD800 && a < 16'hDC00) return color_copy[a[9:0]] | COLOR_PAD;
    case (a)
      ADDR_KEY_SCAN:   return scan_rows(keys);
      ADDR_VIDEO_MODE: return video_mode;
      ADDR_BORDER:     return {4'h0, border_nib};
      ADDR_BACKGROUND: return {4'h0, background_nib};
      ADDR_KEY_COLUMN: return key_column;
      default:         return 8'h00;
    endcase
  endfunction

  // Apply one access to the shadow state and return the result it causes
  function automatic out_item_t predict_access(in_item_t it);
    out_item_t  r;
    logic [9:0] off;
    logic [7:0] scr;
    r = '0;
    case (it.cmd)
      CMD_READ: begin
        r.read_data = read_byte(it.address, it.key_matrix);
      end
      CMD_WRITE: begin
        if (it.address < 16'hD000 || it.address >= 16'hE000 || ram_copy[1][2:0] == 3'd0) begin
          if (ram_copy[it.address] != it.write_data) begin
            ram_copy[it.address] = it.write_data;
            if (it.address >= 16'd1024 && it.address < 16'd2024) begin
              r.redraw_kind = RD_CELL;
              r.cell_index  = it.address[9:0];
            end
          end
        end else if (it.address == ADDR_VIDEO_MODE) begin
          video_mode    = it.write_data;
          r.redraw_kind = RD_SCREEN;
        end else if (it.address == ADDR_BORDER) begin
          border_nib     = it.write_data[3:0];
          r.redraw_kind  = RD_BORDER;
          r.border_value = it.write_data;
        end else if (it.address == ADDR_BACKGROUND) begin
          background_nib = it.write_data[3:0];
          r.redraw_kind  = RD_SCREEN;
        end else if (it.address >= 16'hD800 && it.address < 16'hDC00) begin
          off = it.address[9:0];
          if (color_copy[off] != it.write_data) begin
            color_copy[off] = it.write_data;
            scr = ram_copy[{6'd1, off}];
            if (scr != CHAR_SPACE && scr != CHAR_SHIFTED_SPACE) begin
              r.redraw_kind = RD_CELL;
              r.cell_index  = off;
            end
          end
        end else if (it.address == ADDR_KEY_COLUMN) begin
          key_column = it.write_data;
        end
      end
      CMD_LOAD: begin
        if (it.address >= 16'hA000 && it.address < 16'hC000) begin
          basic_copy[it.address[12:0]] = it.write_data;
        end else if (it.address >= 16'hD000 && it.address < 16'hE000) begin
          glyph_copy[it.address[11:0]] = it.write_data;
        end else if (it.address >= 16'hE000) begin
          kernel_copy[it.address[12:0]] = it.write_data;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Compare each result transfer, then predict each access transfer
  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_item_t want;
    if (!rst_ni) begin
      for (int i = 0; i < RAM_BYTES; i++) ram_copy[i] = 8'h00;
      for (int i = 0; i < COLOR_CELLS; i++) color_copy[i] = 8'h00;
      for (int i = 0; i < BASIC_BYTES; i++) basic_copy[i] = 8'h00;
      for (int i = 0; i < KERNEL_BYTES; i++) kernel_copy[i] = 8'h00;
      for (int i = 0; i < GLYPH_BYTES; i++) glyph_copy[i] = 8'h00;
      ram_copy[0]    = RAM0_RESET;
      ram_copy[1]    = RAM1_RESET;
      video_mode     = 8'h00;
      key_column     = 8'h00;
      border_nib     = 4'h0;
      background_nib = 4'h0;
      expected_results.delete();
      mismatches     = 0;
      results_seen   = 0;
      pending_o      <= 0;
      fail_count_o   <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result transfer with no access outstanding");
        end else begin
          want = expected_results.pop_front();
          if (out_data_i.read_data !== want.read_data)
            report_mismatch($sformatf("read_data got %02h want %02h",
                                      out_data_i.read_data, want.read_data));
          if (out_data_i.redraw_kind !== want.redraw_kind)
            report_mismatch($sformatf("redraw_kind got %0d want %0d",
                                      out_data_i.redraw_kind, want.redraw_kind));
          if (out_data_i.cell_index !== want.cell_index)
            report_mismatch($sformatf("cell_index got %0d want %0d",
                                      out_data_i.cell_index, want.cell_index));
          if (out_data_i.border_value !== want.border_value)
            report_mismatch($sformatf("border_value got %02h want %02h",
                                      out_data_i.border_value, want.border_value));
        end
        results_seen++;
      end
      if (in_valid_i && in_ready_i) begin
        expected_results.push_back(predict_access(in_data_i));
      end
      pending_o    <= expected_results.size();
      fail_count_o <= mismatches;
    end
  end

endmodule
`default_nettype wire

@@ bench/testbench.sv @@
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bmmd_pkg::*;

  localparam int HOLD_CYCLES      = 300;
  localparam int ITEMS_PER_PHASE  = 345;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  int        fail_count;
  int        pending;

  int send_idle_pct;
  int stall_pct;
  bit hold_request;

  // Stimulus-side view of the bank byte and of which ROM bytes hold data
  logic [7:0] bank_mirror;
  bit basic_loaded  [BASIC_BYTES];
  bit kernel_loaded [KERNEL_BYTES];
  bit glyph_loaded  [GLYPH_BYTES];

  banked_memory_map_decoder uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  bmmd_bus_checker checker_inst (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bound the run, with room for the post-reset RAM sweep
  initial begin
    #8_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Flag reads that would land on a ROM byte never loaded
  function automatic bit unloaded_rom_read(in_item_t it);
    logic [15:0] a;
    a = it.address;
    if (it.cmd != CMD_READ) return 1'b0;
    if (a >= 16'hA000 && a < 16'hC000)
      return (bank_mirror[1:0] == 2'b11) && !basic_loaded[a[12:0]];
    if (a >= 16'hE000)
      return bank_mirror[1] && !kernel_loaded[a[12:0]];
    if (a >= 16'hD000)
      return (bank_mirror[1:0] != 2'b00) && !bank_mirror[2] && !glyph_loaded[a[11:0]];
    return 1'b0;
  endfunction

  // Offer one access and hold it until the transfer
  task automatic send_access(in_item_t it);
    if (unloaded_rom_read(it)) it.cmd = CMD_LOAD;
    if (it.cmd == CMD_WRITE && it.address == 16'd1) bank_mirror = it.write_data;
    if (it.cmd == CMD_LOAD) begin
      if (it.address >= 16'hA000 && it.address < 16'hC000) basic_loaded[it.address[12:0]] = 1'b1;
      else if (it.address >= 16'hE000) kernel_loaded[it.address[12:0]] = 1'b1;
      else if (it.address >= 16'hD000) glyph_loaded[it.address[11:0]] = 1'b1;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic put(cmd_e c, logic [15:0] a, logic [7:0] d, logic [63:0] k = '0);
    in_item_t it;
    it.cmd        = c;
    it.address    = a;
    it.write_data = d;
    it.key_matrix = k;
    send_access(it);
  endtask

  // Drop valid and wait for every outstanding result
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(5))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return CHAR_SPACE;
      3:       return CHAR_SHIFTED_SPACE;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [63:0] pick_keys();
    case ($urandom_range(2))
      0:       return {$urandom, $urandom};
      1:       return 64'd1 << $urandom_range(63);
      default: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
    endcase
  endfunction

  // Accesses biased toward the bank byte, screen, ROM bounds, I/O and color RAM
  function automatic in_item_t random_access();
    in_item_t   it;
    int         r;
    logic [15:0] base;
    r = $urandom_range(99);
    if (r < 45) it.cmd = CMD_READ;
    else if (r < 85) it.cmd = CMD_WRITE;
    else if (r < 97) it.cmd = CMD_LOAD;
    else it.cmd = CMD_NOP;
    case ($urandom_range(9))
      0: it.address = 16'($urandom_range(1));
      1, 2: it.address = 16'h0400 + 16'($urandom_range(1) ? $urandom_range(31)
                                                         : $urandom_range(1023));
      3: begin
        case ($urandom_range(2))
          0: base = 16'hA000;
          1: base = 16'hD000;
          default: base = 16'hE000;
        endcase
        if ($urandom_range(3) == 0) it.address = base + ((base == 16'hD000) ? 16'h0FFF : 16'h1FFF);
        else it.address = base + 16'($urandom_range(15));
      end
      4, 5: begin
        case ($urandom_range(5))
          0: it.address = ADDR_VIDEO_MODE;
          1: it.address = ADDR_BORDER;
          2: it.address = ADDR_BACKGROUND;
          3: it.address = ADDR_KEY_COLUMN;
          4: it.address = ADDR_KEY_SCAN;
          default: it.address = 16'hD000 + 16'($urandom_range(4095));
        endcase
      end
      6, 7: begin
        case ($urandom_range(2))
          0: it.address = 16'hD800 + 16'($urandom_range(31));
          1: it.address = 16'hDBFF;
          default: it.address = 16'hD800 + 16'($urandom_range(1023));
        endcase
      end
      default: it.address = 16'($urandom_range(65535));
    endcase
    it.write_data = pick_byte();
    it.key_matrix = pick_keys();
    return it;
  endfunction

  // Receiver: random stalls plus one long hold-off on request
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Main stimulus and verdict
  initial begin
    in_valid      <= 1'b0;
    in_data       <= '0;
    rst_n         <= 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_request  = 1'b0;
    bank_mirror   = RAM1_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset bytes, ROM bounds, I/O registers, color and screen bounds
    put(CMD_READ,  16'h0000, 8'h00);
    put(CMD_READ,  16'h0001, 8'h00);
    put(CMD_LOAD,  16'hA000, 8'h11);
    put(CMD_LOAD,  16'hBFFF, 8'h22);
    put(CMD_LOAD,  16'hE000, 8'h33);
    put(CMD_LOAD,  16'hFFFF, 8'hFF);
    put(CMD_LOAD,  16'hC000, 8'h44);
    put(CMD_READ,  16'hA000, 8'h00);
    put(CMD_READ,  16'hBFFF, 8'h00);
    put(CMD_READ,  16'hFFFF, 8'h00);
    put(CMD_READ,  ADDR_KEY_SCAN, 8'h00, '1);
    put(CMD_READ,  ADDR_KEY_SCAN, 8'h00, '0);
    put(CMD_WRITE, ADDR_KEY_COLUMN, 8'hFE);
    put(CMD_READ,  ADDR_KEY_SCAN, 8'h00, 64'h0000_0000_0000_0100);
    put(CMD_WRITE, ADDR_VIDEO_MODE, 8'hA5);
    put(CMD_WRITE, ADDR_BORDER, 8'hFE);
    put(CMD_WRITE, ADDR_BACKGROUND, 8'h13);
    put(CMD_READ,  ADDR_BORDER, 8'h00);
    put(CMD_WRITE, 16'hDBFF, 8'h0F);
    put(CMD_WRITE, 16'hDBFF, 8'h0F);
    put(CMD_READ,  16'hDBFF, 8'h00);
    put(CMD_WRITE, 16'h07E7, 8'hFF);
    put(CMD_WRITE, 16'h07E8, 8'h01);
    put(CMD_WRITE, 16'h0001, 8'h00);
    put(CMD_WRITE, 16'hD000, 8'h5A);
    put(CMD_READ,  16'hD000, 8'h00);
    put(CMD_WRITE, 16'h0001, 8'h07);
    put(CMD_NOP,   16'hFFFF, 8'hFF, '1);
    wait_drain();

    // Random phases: free-running with one long hold-off, sender idle, receiver stalling, both light
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  hold_request = 1'b1; end
        1: begin send_idle_pct = 78; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 78; end
        default: begin send_idle_pct = 8; stall_pct = 8; end
      endcase
      repeat (ITEMS_PER_PHASE) send_access(random_access());
      wait_drain();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
